// File: sv/s39m_pkg.sv
`timescale 1ns / 1ps
// s39m_pkg: shared constants, types and codes for the Sv39 page-table mapper.
// No dependencies; every other file of the block but s39m_ram imports it.

package s39m_pkg;

    localparam int POOL_PAGES   = 64;
    localparam int PAGE_W       = $clog2(POOL_PAGES);
    localparam int NFP_W        = $clog2(POOL_PAGES + 1);
    localparam int SLOT_W       = 9;
    localparam int ADDR_W       = PAGE_W + SLOT_W;
    localparam int STORE_DEPTH  = POOL_PAGES * (2 ** SLOT_W);

    localparam int PTE_W        = 64;
    localparam int PPN_W        = 44;
    localparam int FLAGS_W      = 10;
    localparam int PTE_PPN_LSB  = 10;
    localparam int VA_W         = 39;
    localparam int PA_W         = 56;
    localparam int OFF_W        = 12;
    localparam int VPN2_LSB     = 30;
    localparam int VPN1_LSB     = 21;
    localparam int VPN0_LSB     = 12;
    localparam int LIMIT_W      = 7;
    localparam int STATUS_W     = 2;
    localparam int ADDED_W      = 2;
    localparam int RPAGE_W      = 6;

    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 64;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 7'd64;
    localparam logic [CFG_ADDR_W-1:0] CFG_POOL_BASE  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POOL_LIMIT = 4'd1;
    localparam logic                  CMD_MAP        = 1'b0;
    localparam logic                  CMD_READ       = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_BAD_VA = 2'd1,
        STATUS_BAD_PA = 2'd2,
        STATUS_NO_MEM = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_MAP,
        OP_READ,
        OP_BAD_VA,
        OP_BAD_PA
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_LEAF
    } state_t;

    // Decoded command handed from the front end to the walker
    typedef struct packed {
        op_kind_t            kind;
        logic [SLOT_W-1:0]   vpn2;
        logic [SLOT_W-1:0]   vpn1;
        logic [SLOT_W-1:0]   vpn0;
        logic [PTE_W-1:0]    leaf;
        logic [ADDR_W-1:0]   rd_addr;
        logic                rd_ok;
    } op_t;

endpackage

// File: sv/s39m_if.sv
`timescale 1ns / 1ps
// s39m_if: valid/ready channel interfaces for request, response and config.
// Depends on s39m_pkg.

interface s39m_req_if;
    import s39m_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [VA_W-1:0]      virt_addr;
    logic [PA_W-1:0]      phys_addr;
    logic [FLAGS_W-1:0]   leaf_flags;
    logic [RPAGE_W-1:0]   read_page;
    logic [SLOT_W-1:0]    read_slot;

    modport source (output valid, cmd, virt_addr, phys_addr, leaf_flags, read_page, read_slot,
                    input ready);
    modport sink   (input valid, cmd, virt_addr, phys_addr, leaf_flags, read_page, read_slot,
                    output ready);
endinterface

interface s39m_rsp_if;
    import s39m_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PTE_W-1:0]     entry_value;
    logic [ADDED_W-1:0]   tables_added;

    modport source (output valid, status, entry_value, tables_added, input ready);
    modport sink   (input valid, status, entry_value, tables_added, output ready);
endinterface

interface s39m_cfg_if;
    import s39m_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_ADDR_W-1:0]  addr;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: sv/sv39_page_table_mapper_unit.sv
`timescale 1ns / 1ps
// sv39_page_table_mapper_unit: top level, config registers, front end and walker.
// Depends on s39m_pkg, s39m_if, s39m_front, s39m_back (and s39m_ram below it).
//
// Usage:
//   req  - command beats: map (walk levels 2/1/0, link new pool pages, write leaf)
//          or read (return one stored entry). Up to two beats queue ahead.
//   rsp  - one beat per command: status, entry_value, tables_added. The
//          response sits in an output register; while rsp is stalled the front
//          end still takes beats until its two-entry queue is full.
//   cfg  - register writes (0 pool_base_ppn, 1 pool_limit); ready is always
//          high. Write only while no command is in flight.
// Sequencing, once a command reaches the walker (one command at a time):
//   map issues the level-2 read on the pop, examines the level-2 and level-1
//   entries in turn through the registered read port, then writes the leaf;
//   read issues its read on the pop and answers from the port; a misaligned
//   request is answered on the pop. With rsp.ready high the next command is
//   popped as the response is taken.
// Reset: the 32768-entry table store is zeroed by a clearing pass, one entry
//   per cycle; req.ready stays low until it completes.
//   next_free_page restarts at 1, pool_base_ppn 0, pool_limit 64.

module sv39_page_table_mapper_unit (
    input  logic        clk,
    input  logic        rst_n,
    s39m_req_if.sink    req,
    s39m_rsp_if.source  rsp,
    s39m_cfg_if.sink    cfg
);
    import s39m_pkg::*;

    logic [PPN_W-1:0]    base_reg, base_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic                q_valid;
    logic                q_pop;
    logic                clearing;
    op_t                 q_op;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        base_next  = base_reg;
        limit_next = limit_reg;
        if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_POOL_BASE:  base_next  = cfg.data[PPN_W-1:0];
                CFG_POOL_LIMIT: limit_next = cfg.data[LIMIT_W-1:0];
                default:        base_next  = base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            base_reg  <= base_next;
            limit_reg <= limit_next;
        end
    end

    s39m_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_op     (q_op)
    );

    s39m_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pool_base  (base_reg),
        .pool_limit (limit_reg),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .rsp        (rsp)
    );

endmodule

// File: sv/s39m_ram.sv
`timescale 1ns / 1ps
// s39m_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.

module s39m_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/s39m_front.sv
`timescale 1ns / 1ps
// s39m_front: accepts request beats, classifies them and queues decoded commands.
// Depends on s39m_pkg and s39m_if.

module s39m_front (
    input  logic             clk,
    input  logic             rst_n,
    s39m_req_if.sink         req,
    input  logic             clearing,
    output logic             q_valid,
    input  logic             q_pop,
    output s39m_pkg::op_t    q_op
);
    import s39m_pkg::*;

    op_t                 queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    op_t                 op_in;
    logic                push;

    // Classification: read first, then virtual alignment, then physical
    always_comb
    begin
        op_in.vpn2    = req.virt_addr[VPN2_LSB +: SLOT_W];
        op_in.vpn1    = req.virt_addr[VPN1_LSB +: SLOT_W];
        op_in.vpn0    = req.virt_addr[VPN0_LSB +: SLOT_W];
        op_in.leaf    = {(PTE_W - PPN_W - FLAGS_W)'(0), req.phys_addr[PA_W-1:OFF_W],
                         req.leaf_flags[FLAGS_W-1:1], 1'b1};
        op_in.rd_addr = {PAGE_W'(req.read_page), req.read_slot};
        op_in.rd_ok   = ({1'b0, req.read_page} < POOL_PAGES);
        if (req.cmd == CMD_READ)
        begin
            op_in.kind = OP_READ;
        end
        else if (req.virt_addr[OFF_W-1:0] != '0)
        begin
            op_in.kind = OP_BAD_VA;
        end
        else if (req.phys_addr[OFF_W-1:0] != '0)
        begin
            op_in.kind = OP_BAD_PA;
        end
        else
        begin
            op_in.kind = OP_MAP;
        end
    end

    assign req.ready = !clearing && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_op      = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

// File: sv/s39m_back.sv
`timescale 1ns / 1ps
// s39m_back: table walker and allocator over the table store, plus the response register.
// Depends on s39m_pkg, s39m_if and s39m_ram.

module s39m_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [s39m_pkg::PPN_W-1:0]    pool_base,
    input  logic [s39m_pkg::LIMIT_W-1:0]  pool_limit,
    input  logic                          q_valid,
    input  s39m_pkg::op_t                 q_op,
    output logic                          q_pop,
    output logic                          clearing,
    s39m_rsp_if.source                    rsp
);
    import s39m_pkg::*;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [NFP_W-1:0]     nfp_reg, nfp_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic                 top_reg, top_next;
    logic [ADDED_W-1:0]   added_reg, added_next;
    op_t                  op_reg, op_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [PTE_W-1:0]     entry_reg, entry_next;
    logic [ADDED_W-1:0]   tadd_reg, tadd_next;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [PTE_W-1:0]     wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [PTE_W-1:0]     rd_data;

    logic [PPN_W-1:0]     ptr_ppn;
    logic [PTE_W-1:0]     ptr_pte;
    logic [PPN_W-1:0]     entry_idx;
    logic                 idx_bad;
    logic                 pool_full;
    logic [ADDR_W-1:0]    cur_addr;
    logic [PAGE_W-1:0]    new_page;
    logic                 out_free;

    s39m_ram #(
        .WIDTH (PTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign ptr_ppn   = pool_base + PPN_W'(nfp_reg);
    assign ptr_pte   = {(PTE_W - PPN_W - PTE_PPN_LSB)'(0), ptr_ppn,
                        (PTE_PPN_LSB - 1)'(0), 1'b1};
    // pointer back to a pool page index, modulo 2^44
    assign entry_idx = rd_data[PTE_PPN_LSB +: PPN_W] - pool_base;
    assign idx_bad   = (entry_idx >= PPN_W'(POOL_PAGES));
    assign pool_full = (nfp_reg >= pool_limit) || (nfp_reg >= POOL_PAGES);
    assign cur_addr  = {page_reg, top_reg ? op_reg.vpn2 : op_reg.vpn1};
    assign out_free  = !out_valid_reg || rsp.ready;
    assign clearing  = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        nfp_next       = nfp_reg;
        page_next      = page_reg;
        top_next       = top_reg;
        added_next     = added_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        entry_next     = entry_reg;
        tadd_next      = tadd_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = clr_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = q_op.rd_addr;
        new_page       = entry_idx[PAGE_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_op;
                    page_next  = '0;
                    top_next   = 1'b1;
                    added_next = '0;
                    case (q_op.kind)
                        OP_READ:
                        begin
                            rd_en      = q_op.rd_ok;
                            state_next = ST_READ;
                        end
                        OP_BAD_VA:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_BAD_VA;
                            entry_next     = '0;
                            tadd_next      = '0;
                        end
                        OP_BAD_PA:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_BAD_PA;
                            entry_next     = '0;
                            tadd_next      = '0;
                        end
                        OP_MAP:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = {PAGE_W'(0), q_op.vpn2};
                            state_next = ST_LOOK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                out_valid_next = 1'b1;
                status_next    = STATUS_OK;
                entry_next     = op_reg.rd_ok ? rd_data : '0;
                tadd_next      = '0;
                state_next     = ST_IDLE;
            end

            ST_LOOK:
            begin
                if ((!rd_data[0] && pool_full) || (rd_data[0] && idx_bad))
                begin
                    // no next level: earlier links stay in place
                    out_valid_next = 1'b1;
                    status_next    = STATUS_NO_MEM;
                    entry_next     = '0;
                    tadd_next      = added_reg;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    if (!rd_data[0])
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = cur_addr;
                        wr_data    = ptr_pte;
                        new_page   = nfp_reg[PAGE_W-1:0];
                        nfp_next   = nfp_reg + 1'b1;
                        added_next = added_reg + 1'b1;
                    end
                    page_next = new_page;
                    if (top_reg)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = {new_page, op_reg.vpn1};
                        top_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_LEAF;
                    end
                end
            end

            ST_LEAF:
            begin
                wr_en          = 1'b1;
                wr_addr        = {page_reg, op_reg.vpn0};
                wr_data        = op_reg.leaf;
                out_valid_next = 1'b1;
                status_next    = STATUS_OK;
                entry_next     = op_reg.leaf;
                tadd_next      = added_reg;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            nfp_reg       <= NFP_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            nfp_reg       <= nfp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg   <= page_next;
        top_reg    <= top_next;
        added_reg  <= added_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        entry_reg  <= entry_next;
        tadd_reg   <= tadd_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.entry_value  = entry_reg;
    assign rsp.tables_added = tadd_reg;

    a_nfp_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        nfp_reg <= NFP_W'(POOL_PAGES))
        else $error("allocator ran past the pool");

    a_no_beat_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid_reg)
        else $error("response beat during the clearing pass");

    a_link_only_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK && wr_en) |-> !rd_data[0])
        else $error("valid entry overwritten during walk");

    a_pop_progress: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != ST_IDLE) || out_valid_reg)
        else $error("popped command produced no work");

endmodule
